@@ hdl/smc_pkg.sv @@
`default_nettype none

package smc_pkg;

  // Position register width; positions wrap at this width.
  localparam int PosW = 32;

  localparam int PeriodW  = 16;
  localparam int SinceW   = 17;
  localparam int SpeedW   = 7;
  localparam int ProductW = 24;
  localparam int ShareW   = 17;

  localparam logic [SpeedW-1:0]  SpeedFull = 7'd100;
  localparam logic [SinceW-1:0]  SinceMax  = 17'h1FFFF;
  localparam logic [PeriodW-1:0] MinReset  = 16'd400;
  localparam logic [PeriodW-1:0] MaxReset  = 16'd4000;

  // x / 100 == (x * RecipMul) >> RecipShift for every |x| <= 65535 * 100
  localparam logic [23:0] RecipMul   = 24'd10737419;
  localparam int          RecipShift = 30;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_START     = 3'd1,
    ACT_ABORT     = 3'd2,
    ACT_POWER_ON  = 3'd3,
    ACT_POWER_OFF = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    RES_REACHED   = 2'd0,
    RES_POWER_OFF = 2'd1,
    RES_ABORTED   = 2'd2
  } result_e;

  typedef enum logic [1:0] {
    PH_CHECK = 2'd0,
    PH_RAISE = 2'd1,
    PH_COUNT = 2'd2,
    PH_FALL  = 2'd3
  } phase_e;

  typedef enum logic {
    CFG_MIN_PERIOD = 1'b0,
    CFG_MAX_PERIOD = 1'b1
  } cfg_e;

endpackage

`default_nettype wire

@@ hdl/smc_speed_div.sv @@
`default_nettype none

module smc_speed_div
  import smc_pkg::*;
(
  input  logic signed [ProductW-1:0] prod_i,
  output logic signed [ShareW-1:0]   share_o
);

  logic                  neg;
  logic [ProductW-2:0]   mag;
  logic [ProductW-1:0]   neg_prod;
  logic [ProductW+23:0]  scaled;
  logic [PeriodW-1:0]    quot;

  assign neg      = prod_i[ProductW-1];
  assign neg_prod = -prod_i;
  assign mag      = neg ? neg_prod[ProductW-2:0] : prod_i[ProductW-2:0];
  // reciprocal multiply, quotient truncated toward zero
  assign scaled   = {1'b0, mag} * {{(ProductW){1'b0}}, RecipMul};
  assign quot     = scaled[RecipShift+PeriodW-1:RecipShift];
  assign share_o  = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

`default_nettype wire

@@ hdl/stepper_move_controller.sv @@
`default_nettype none

// Step/direction pulse generator for a stepper driver. Each input item is one
// command (one-microsecond tick, start move, abort, power on, power off) and
// yields exactly one result item with the position, power, busy and pin
// levels after that command. One item is accepted per clock cycle unless a
// stalled result output holds the pipeline; an item passes the product
// register, quotient register and result register, a depth set by the speed
// share multiply and its reciprocal divide by 100. A step takes four phases of
// the phase period, which is max_period_us - (max - min) * speed / 100 ticks; a
// reversal waits for twice (min_period_us + share), less the time since the
// last step. Abort and power off stop a move at its next check phase. The
// user must write the period registers only while no item is in flight; the
// block does not enforce this. The configuration port is always ready.
module stepper_move_controller
  import smc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [PeriodW-1:0]       cfg_data_i,
  // command items
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               action_i,
  input  logic                     relative_i,
  input  logic signed [PosW-1:0]   steps_i,
  input  logic [SpeedW-1:0]        speed_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [PosW-1:0]   position_o,
  output logic                     position_valid_o,
  output logic                     powered_o,
  output logic                     busy_res_o,
  output logic                     step_level_o,
  output logic                     dir_level_o,
  output logic                     move_done_o,
  output logic [1:0]               move_result_o,
  output logic                     accepted_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PeriodW-1:0] min_q, max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinReset;
      max_q <= MaxReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_MIN_PERIOD: min_q <= cfg_data_i;
        CFG_MAX_PERIOD: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: stage 1 (product), stage 2 (share), result register
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_adv, s2_free, s1_adv, s1_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_adv     = s2_valid_q && out_free;     // item executes against state
  assign s2_free    = !s2_valid_q || s2_adv;
  assign s1_adv     = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s1_adv;
  assign in_ready_o = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: (max - min) * speed, speed clamped to full
  // ---------------------------------------------------------------------------
  logic [SpeedW-1:0]         speed_c;
  logic signed [16:0]        diff_s;
  logic signed [7:0]         speed_s;
  logic signed [24:0]        prod_full;

  logic [2:0]                s1_action_q;
  logic                      s1_rel_q;
  logic [PosW-1:0]           s1_steps_q;
  logic signed [ProductW-1:0] s1_prod_q;

  assign speed_c   = (speed_i > SpeedFull) ? SpeedFull : speed_i;
  assign diff_s    = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
  assign speed_s   = $signed({1'b0, speed_c});
  assign prod_full = diff_s * speed_s;

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_action_q <= action_i;
      s1_rel_q    <= relative_i;
      s1_steps_q  <= steps_i;
      s1_prod_q   <= prod_full[ProductW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: share = product / 100, truncated toward zero
  // ---------------------------------------------------------------------------
  logic signed [ShareW-1:0]  share;
  logic [2:0]                s2_action_q;
  logic                      s2_rel_q;
  logic [PosW-1:0]           s2_steps_q;
  logic signed [ShareW-1:0]  s2_share_q;

  smc_speed_div u_div (
    .prod_i  (s1_prod_q),
    .share_o (share)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_action_q <= s1_action_q;
      s2_rel_q    <= s1_rel_q;
      s2_steps_q  <= s1_steps_q;
      s2_share_q  <= share;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state and command execution
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]    cur_q, cur_d, target_q, target_d;
  logic               powered_q, powered_d, abort_q, abort_d, moving_q, moving_d;
  phase_e             phase_q, phase_d;
  logic [SinceW-1:0]  cd_q, cd_d, since_q, since_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic               last_pos_q, last_pos_d, mpos_q, mpos_d;
  logic               step_q, step_d, dir_q, dir_d;
  result_e            result_q, result_d;
  logic               done, acc;

  // start-move helpers
  logic [PosW-1:0]    tgt;
  logic               tgt_gt, cur_gt;
  logic signed [17:0] turn_sum, period_sum;
  logic [SinceW-1:0]  turn;

  assign tgt        = s2_rel_q ? (cur_q + s2_steps_q) : s2_steps_q;
  assign tgt_gt     = $signed(tgt) > $signed(cur_q);
  assign cur_gt     = $signed(target_q) > $signed(cur_q);
  // min + share lies between min and max, so it fits 16 bits unsigned
  assign turn_sum   = $signed({2'b00, min_q}) + {s2_share_q[ShareW-1], s2_share_q};
  assign period_sum = $signed({2'b00, max_q}) - {s2_share_q[ShareW-1], s2_share_q};
  assign turn       = {turn_sum[PeriodW-1:0], 1'b0};

  always_comb begin
    cur_d      = cur_q;
    target_d   = target_q;
    powered_d  = powered_q;
    abort_d    = abort_q;
    moving_d   = moving_q;
    phase_d    = phase_q;
    cd_d       = cd_q;
    period_d   = period_q;
    since_d    = since_q;
    last_pos_d = last_pos_q;
    mpos_d     = mpos_q;
    step_d     = step_q;
    dir_d      = dir_q;
    result_d   = result_q;
    done       = 1'b0;
    acc        = 1'b0;
    unique case (action_e'(s2_action_q))
      ACT_TICK: begin
        if (since_q != SinceMax) begin
          since_d = since_q + 1'b1;
        end
        if (moving_q) begin
          if (cd_q <= 17'd1) begin
            cd_d = {1'b0, period_q};
            unique case (phase_q)
              PH_CHECK: begin
                if (!powered_q) begin
                  moving_d = 1'b0;
                  result_d = RES_POWER_OFF;
                  done     = 1'b1;
                end else if (abort_q) begin
                  moving_d = 1'b0;
                  result_d = RES_ABORTED;
                  done     = 1'b1;
                end else if (target_q == cur_q) begin
                  moving_d = 1'b0;
                  result_d = RES_REACHED;
                  done     = 1'b1;
                end else begin
                  mpos_d  = cur_gt;
                  dir_d   = !cur_gt;
                  phase_d = PH_RAISE;
                end
              end
              PH_RAISE: begin
                step_d     = 1'b1;
                since_d    = '0;
                last_pos_d = mpos_q;
                phase_d    = PH_COUNT;
              end
              PH_COUNT: begin
                if (powered_q) begin
                  cur_d = mpos_q ? (cur_q + 1'b1) : (cur_q - 1'b1);
                end
                phase_d = PH_FALL;
              end
              PH_FALL: begin
                step_d  = 1'b0;
                phase_d = PH_CHECK;
              end
            endcase
          end else begin
            cd_d = cd_q - 1'b1;
          end
        end
      end
      ACT_START: begin
        if (!moving_q) begin
          if (!powered_q) begin
            result_d = RES_POWER_OFF;
            done     = 1'b1;
          end else begin
            target_d = tgt;
            if (tgt == cur_q) begin
              result_d = RES_REACHED;
              done     = 1'b1;
            end else begin
              abort_d  = 1'b0;
              // reversal: wait out the remainder of the turn delay
              if ((tgt_gt != last_pos_q) && (since_q < turn)) begin
                cd_d = turn - since_q;
              end else begin
                cd_d = '0;
              end
              period_d = period_sum[PeriodW-1:0];
              phase_d  = PH_CHECK;
              moving_d = 1'b1;
              acc      = 1'b1;
            end
          end
        end
      end
      ACT_ABORT: begin
        if (powered_q) begin
          abort_d = 1'b1;
          acc     = 1'b1;
        end
      end
      ACT_POWER_ON: begin
        if (!powered_q) begin
          powered_d = 1'b1;
          acc       = 1'b1;
        end
      end
      ACT_POWER_OFF: begin
        if (powered_q) begin
          powered_d = 1'b0;
          cur_d     = '0;
          acc       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      target_q   <= '0;
      powered_q  <= 1'b0;
      abort_q    <= 1'b0;
      moving_q   <= 1'b0;
      phase_q    <= PH_CHECK;
      cd_q       <= '0;
      period_q   <= '0;
      since_q    <= SinceMax;
      last_pos_q <= 1'b0;
      mpos_q     <= 1'b0;
      step_q     <= 1'b0;
      dir_q      <= 1'b0;
      result_q   <= RES_REACHED;
    end else if (s2_adv) begin
      cur_q      <= cur_d;
      target_q   <= target_d;
      powered_q  <= powered_d;
      abort_q    <= abort_d;
      moving_q   <= moving_d;
      phase_q    <= phase_d;
      cd_q       <= cd_d;
      period_q   <= period_d;
      since_q    <= since_d;
      last_pos_q <= last_pos_d;
      mpos_q     <= mpos_d;
      step_q     <= step_d;
      dir_q      <= dir_d;
      result_q   <= result_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] out_pos_q;
  logic            out_pwr_q, out_busy_q, out_step_q, out_dir_q, out_done_q, out_acc_q;
  logic [1:0]      out_res_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_pos_q  <= powered_d ? cur_d : '0;
      out_pwr_q  <= powered_d;
      out_busy_q <= moving_d;
      out_step_q <= step_d;
      out_dir_q  <= dir_d;
      out_done_q <= done;
      out_res_q  <= result_d;
      out_acc_q  <= acc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_o       = out_pos_q;
  assign position_valid_o = out_pwr_q;
  assign powered_o        = out_pwr_q;
  assign busy_res_o       = out_busy_q;
  assign step_level_o     = out_step_q;
  assign dir_level_o      = out_dir_q;
  assign move_done_o      = out_done_q;
  assign move_result_o    = out_res_q;
  assign accepted_o       = out_acc_q;

`ifndef ASSERT_OFF
  // the step pin is only high inside a running move
  a_step_in_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q |-> moving_q)
    else $error("step pin high with no move running");

  // phases other than check only occur while a move runs
  a_phase_in_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_CHECK) |-> moving_q)
    else $error("step phase advanced outside a move");

  // position is held at zero while the driver is off
  a_pos_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !powered_q |-> (cur_q == '0))
    else $error("position moved while powered off");

  // the step timer only moves when an item executes
  a_since_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_adv |=> $stable(since_q) && $stable(cd_q))
    else $error("timer changed with no item executing");
`endif

endmodule

`default_nettype wire
